@@ rtl/hcm_pkg.sv @@
// shared types and constants for the homography coordinate mapper
// no dependencies
package hcm_pkg;

    localparam int COEF_BITS = 48;
    localparam int SUM_BITS  = 64;
    localparam int INT_BITS  = 10;
    localparam int FRAC_BITS = 16;
    localparam int QUOT_BITS = INT_BITS + FRAC_BITS;
    localparam int NUM_COEFS = 8;
    localparam int CFG_INDEX_BITS = 4;

    localparam int DEF_SRC_HEIGHT   = 512;
    localparam int DEF_SRC_WIDTH    = 512;
    localparam int DEF_OUT_ROW_BITS = 11;
    localparam int DEF_OUT_COL_BITS = 12;

    localparam logic [COEF_BITS-1:0] COEF_ONE  = 48'h0001_0000_0000;
    localparam logic [SUM_BITS-1:0]  SUM_ONE   = 64'h0000_0001_0000_0000;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_COEF_00 = 4'd0,
        CFG_COEF_01 = 4'd1,
        CFG_COEF_02 = 4'd2,
        CFG_COEF_10 = 4'd3,
        CFG_COEF_11 = 4'd4,
        CFG_COEF_12 = 4'd5,
        CFG_COEF_20 = 4'd6,
        CFG_COEF_21 = 4'd7
    } cfg_index_t;

    typedef struct packed {
        logic signed [COEF_BITS-1:0] c00;
        logic signed [COEF_BITS-1:0] c01;
        logic signed [COEF_BITS-1:0] c02;
        logic signed [COEF_BITS-1:0] c10;
        logic signed [COEF_BITS-1:0] c11;
        logic signed [COEF_BITS-1:0] c12;
        logic signed [COEF_BITS-1:0] c20;
        logic signed [COEF_BITS-1:0] c21;
    } coef_set_t;

endpackage

@@ rtl/homography_coordinate_mapper_unit.sv @@
// Maps each output pixel coordinate through a programmable 3x3 homography
// (last entry 1.0) to a source position with integer parts and 16-bit
// fractions plus an interior flag. One transfer is accepted per clock
// unless the output stalls; the stages are one multiply stage, one sum stage,
// a range check stage, 26 restoring divide stages (one quotient bit each) and
// the output register. A stall on the output freezes the whole pipeline.
// depends on hcm_pkg, hcm_mult_sum, hcm_div_lane
module homography_coordinate_mapper_unit
    import hcm_pkg::*;
#(
    parameter int SRC_HEIGHT   = DEF_SRC_HEIGHT,
    parameter int SRC_WIDTH    = DEF_SRC_WIDTH,
    parameter int OUT_ROW_BITS = DEF_OUT_ROW_BITS,
    parameter int OUT_COL_BITS = DEF_OUT_COL_BITS
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [COEF_BITS-1:0]      cfg_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [OUT_ROW_BITS-1:0]   out_row,
    input  logic [OUT_COL_BITS-1:0]   out_col,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic                      inside_res,
    output logic [INT_BITS-1:0]       src_row_int,
    output logic [INT_BITS-1:0]       src_col_int,
    output logic [FRAC_BITS-1:0]      row_frac,
    output logic [FRAC_BITS-1:0]      col_frac
);

    localparam int DEPTH = 2 + 1 + QUOT_BITS;

    coef_set_t coef_reg;
    logic en;
    logic vpipe_reg [0:DEPTH-1];
    logic signed [SUM_BITS-1:0] nr, nc, d;
    logic ok_r, ok_c;
    logic [QUOT_BITS-1:0] q_r, q_c;
    logic inside_next;

    logic out_valid_reg, inside_reg;
    logic [INT_BITS-1:0]  row_int_reg, col_int_reg;
    logic [FRAC_BITS-1:0] row_frac_reg, col_frac_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg.c00 <= COEF_ONE;
            coef_reg.c01 <= '0;
            coef_reg.c02 <= '0;
            coef_reg.c10 <= '0;
            coef_reg.c11 <= COEF_ONE;
            coef_reg.c12 <= '0;
            coef_reg.c20 <= '0;
            coef_reg.c21 <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_COEF_00: coef_reg.c00 <= cfg_data;
                CFG_COEF_01: coef_reg.c01 <= cfg_data;
                CFG_COEF_02: coef_reg.c02 <= cfg_data;
                CFG_COEF_10: coef_reg.c10 <= cfg_data;
                CFG_COEF_11: coef_reg.c11 <= cfg_data;
                CFG_COEF_12: coef_reg.c12 <= cfg_data;
                CFG_COEF_20: coef_reg.c20 <= cfg_data;
                CFG_COEF_21: coef_reg.c21 <= cfg_data;
                default: ;
            endcase
        end
    end

    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
                vpipe_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            vpipe_reg[0] <= in_valid;
            for (int i = 1; i < DEPTH; i++)
                vpipe_reg[i] <= vpipe_reg[i-1];
        end
    end

    hcm_mult_sum #(
        .OUT_ROW_BITS (OUT_ROW_BITS),
        .OUT_COL_BITS (OUT_COL_BITS)
    ) u_mult_sum (
        .clk     (clk),
        .en      (en),
        .out_row (out_row),
        .out_col (out_col),
        .coefs   (coef_reg),
        .num_row (nr),
        .num_col (nc),
        .den     (d)
    );

    hcm_div_lane #(.LIMIT (SRC_HEIGHT - 2)) u_div_row (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .num   (nr),
        .den   (d),
        .ok    (ok_r),
        .quot  (q_r)
    );

    hcm_div_lane #(.LIMIT (SRC_WIDTH - 2)) u_div_col (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .num   (nc),
        .den   (d),
        .ok    (ok_c),
        .quot  (q_c)
    );

    assign inside_next = ok_r && ok_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= vpipe_reg[DEPTH-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            inside_reg   <= inside_next;
            row_int_reg  <= inside_next ? q_r[QUOT_BITS-1:FRAC_BITS] : '0;
            col_int_reg  <= inside_next ? q_c[QUOT_BITS-1:FRAC_BITS] : '0;
            row_frac_reg <= inside_next ? q_r[FRAC_BITS-1:0] : '0;
            col_frac_reg <= inside_next ? q_c[FRAC_BITS-1:0] : '0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign inside_res  = inside_reg;
    assign src_row_int = row_int_reg;
    assign src_col_int = col_int_reg;
    assign row_frac    = row_frac_reg;
    assign col_frac    = col_frac_reg;

`ifndef NO_ASSERTIONS
    a_zero_outside: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !inside_res |-> src_row_int == '0 && src_col_int == '0 &&
        row_frac == '0 && col_frac == '0)
        else $error("fields not cleared on an outside result");

    a_row_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && inside_res |-> src_row_int >= INT_BITS'(1) &&
        src_row_int <= INT_BITS'(SRC_HEIGHT - 2))
        else $error("inside row out of interior bounds");

    a_col_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && inside_res |-> src_col_int >= INT_BITS'(1) &&
        src_col_int <= INT_BITS'(SRC_WIDTH - 2))
        else $error("inside column out of interior bounds");
`endif

endmodule

@@ rtl/hcm_mult_sum.sv @@
// multiply stage and sum stage: forms the two numerators and the denominator
// depends on hcm_pkg
module hcm_mult_sum
    import hcm_pkg::*;
#(
    parameter int OUT_ROW_BITS = DEF_OUT_ROW_BITS,
    parameter int OUT_COL_BITS = DEF_OUT_COL_BITS
)
(
    input  logic                       clk,
    input  logic                       en,
    input  logic [OUT_ROW_BITS-1:0]    out_row,
    input  logic [OUT_COL_BITS-1:0]    out_col,
    input  coef_set_t                  coefs,
    output logic signed [SUM_BITS-1:0] num_row,
    output logic signed [SUM_BITS-1:0] num_col,
    output logic signed [SUM_BITS-1:0] den
);

    localparam int PR_BITS = COEF_BITS + OUT_ROW_BITS + 1;
    localparam int PC_BITS = COEF_BITS + OUT_COL_BITS + 1;

    logic signed [OUT_ROW_BITS:0] r_s;
    logic signed [OUT_COL_BITS:0] c_s;
    logic signed [PR_BITS-1:0] p00_next, p10_next, p20_next;
    logic signed [PC_BITS-1:0] p01_next, p11_next, p21_next;
    logic signed [PR_BITS-1:0] p00_reg, p10_reg, p20_reg;
    logic signed [PC_BITS-1:0] p01_reg, p11_reg, p21_reg;
    logic signed [COEF_BITS-1:0] c02_reg, c12_reg;
    logic signed [SUM_BITS-1:0] nr_reg, nc_reg, d_reg;

    assign r_s = $signed({1'b0, out_row});
    assign c_s = $signed({1'b0, out_col});

    always_comb
    begin
        p00_next = coefs.c00 * r_s;
        p10_next = coefs.c10 * r_s;
        p20_next = coefs.c20 * r_s;
        p01_next = coefs.c01 * c_s;
        p11_next = coefs.c11 * c_s;
        p21_next = coefs.c21 * c_s;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p00_reg <= p00_next;
            p10_reg <= p10_next;
            p20_reg <= p20_next;
            p01_reg <= p01_next;
            p11_reg <= p11_next;
            p21_reg <= p21_next;
            c02_reg <= coefs.c02;
            c12_reg <= coefs.c12;
            nr_reg  <= SUM_BITS'(p00_reg) + SUM_BITS'(p01_reg) + SUM_BITS'(c02_reg);
            nc_reg  <= SUM_BITS'(p10_reg) + SUM_BITS'(p11_reg) + SUM_BITS'(c12_reg);
            d_reg   <= SUM_BITS'(p20_reg) + SUM_BITS'(p21_reg) + $signed(SUM_ONE);
        end
    end

    assign num_row = nr_reg;
    assign num_col = nc_reg;
    assign den     = d_reg;

endmodule

@@ rtl/hcm_div_lane.sv @@
// pipelined restoring divider for one coordinate with the interior bounds test
// depends on hcm_pkg
module hcm_div_lane
    import hcm_pkg::*;
#(
    parameter int LIMIT = DEF_SRC_HEIGHT - 2
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic signed [SUM_BITS-1:0] num,
    input  logic signed [SUM_BITS-1:0] den,
    output logic                       ok,
    output logic [QUOT_BITS-1:0]       quot
);

    localparam int DB = SUM_BITS - 1;
    localparam int RW = DB + INT_BITS;
    localparam int NS = QUOT_BITS;

    logic [RW-1:0]        rem_reg  [0:NS];
    logic [DB-1:0]        d_reg    [0:NS];
    logic [QUOT_BITS-1:0] quot_reg [0:NS];
    logic                 ok_reg   [0:NS];

    logic den_pos, num_ge, num_lt, ok_next;

    // quotient must land in [1, 2^INT_BITS) to be worth dividing
    always_comb
    begin
        den_pos = !den[SUM_BITS-1] && (den != '0);
        num_ge  = num >= den;
        num_lt  = {{INT_BITS{1'b0}}, num[DB-1:0]} < {den[DB-1:0], {INT_BITS{1'b0}}};
        ok_next = den_pos && num_ge && num_lt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ok_reg[0] <= 1'b0;
        else if (en)
            ok_reg[0] <= ok_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= {{INT_BITS{1'b0}}, num[DB-1:0]};
            d_reg[0]    <= den[DB-1:0];
            quot_reg[0] <= '0;
        end
    end

    for (genvar k = 0; k < NS; k++)
    begin : g_step
        logic [RW-1:0] base;
        logic [RW-1:0] dsh;
        logic [RW:0]   diff;
        logic          bit_next;
        logic          lim_ok;

        always_comb
        begin
            if (k < INT_BITS)
            begin
                base = rem_reg[k];
                dsh  = {{INT_BITS{1'b0}}, d_reg[k]} << (INT_BITS - 1 - k);
            end
            else
            begin
                base = {rem_reg[k][RW-2:0], 1'b0};
                dsh  = {{INT_BITS{1'b0}}, d_reg[k]};
            end
            diff     = {1'b0, base} - {1'b0, dsh};
            bit_next = !diff[RW];
            // exact test against the upper bound once the integer part is known
            if (k == INT_BITS)
                lim_ok = !((quot_reg[k][INT_BITS-1:0] > INT_BITS'(LIMIT)) ||
                           ((quot_reg[k][INT_BITS-1:0] == INT_BITS'(LIMIT)) &&
                            (rem_reg[k] != '0)));
            else
                lim_ok = 1'b1;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                ok_reg[k+1] <= 1'b0;
            else if (en)
                ok_reg[k+1] <= ok_reg[k] && lim_ok;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1]  <= bit_next ? diff[RW-1:0] : base;
                d_reg[k+1]    <= d_reg[k];
                quot_reg[k+1] <= {quot_reg[k][QUOT_BITS-2:0], bit_next};
            end
        end
    end

    assign ok   = ok_reg[NS];
    assign quot = quot_reg[NS];

endmodule

@@ tb/sv/tb_homography_coordinate_mapper_unit.sv @@
// testbench for homography_coordinate_mapper_unit: directed table then random
// coordinates under several coefficient sets, checked against a local mapper model
// depends on hcm_pkg and the rtl of homography_coordinate_mapper_unit
`timescale 1ns / 1ps

module tb_homography_coordinate_mapper_unit;
    import hcm_pkg::*;

    localparam int ROW_W  = DEF_OUT_ROW_BITS;
    localparam int COL_W  = DEF_OUT_COL_BITS;
    localparam int HEIGHT = DEF_SRC_HEIGHT;
    localparam int WIDTH  = DEF_SRC_WIDTH;
    localparam int PIPE_CYCLES = 30;

    typedef struct packed {
        logic                 in_bounds;
        logic [INT_BITS-1:0]  row_i;
        logic [INT_BITS-1:0]  col_i;
        logic [FRAC_BITS-1:0] row_f;
        logic [FRAC_BITS-1:0] col_f;
    } src_pos_t;

    typedef struct {
        logic [ROW_W-1:0] r;
        logic [COL_W-1:0] c;
        bit               fixed;
        src_pos_t         want;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [COEF_BITS-1:0] cfg_data;
    logic in_valid;
    logic in_stall;
    logic [ROW_W-1:0] out_row;
    logic [COL_W-1:0] out_col;
    logic out_valid;
    logic out_stall;
    logic inside_res;
    logic [INT_BITS-1:0] src_row_int;
    logic [INT_BITS-1:0] src_col_int;
    logic [FRAC_BITS-1:0] row_frac;
    logic [FRAC_BITS-1:0] col_frac;

    homography_coordinate_mapper_unit dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .out_row(out_row), .out_col(out_col),
        .out_valid(out_valid), .out_stall(out_stall),
        .inside_res(inside_res), .src_row_int(src_row_int),
        .src_col_int(src_col_int), .row_frac(row_frac), .col_frac(col_frac)
    );

    logic signed [COEF_BITS-1:0] coefs [NUM_COEFS];
    src_pos_t pending_pos [$];
    int mismatches;
    int checked;
    int inside_seen;
    bit stim_done;
    bit drain_hold;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("timeout");
        $display("FAIL homography_coordinate_mapper_unit");
        $finish;
    end

    // exact quotient check and 16-bit truncated fraction
    function automatic bit div_bounded(input logic signed [SUM_BITS-1:0] num,
                                       input logic signed [SUM_BITS-1:0] den,
                                       input longint unsigned lim,
                                       output logic [INT_BITS-1:0] ip,
                                       output logic [FRAC_BITS-1:0] fp);
        longint unsigned n, d, q, rem;
        logic [FRAC_BITS-1:0] f;
        n = 0;
        ip = '0;
        fp = '0;
        f = '0;
        if (num < den)
            return 1'b0;
        n = num;
        d = den;
        q = n / d;
        rem = n % d;
        if (q > lim || (q == lim && rem != 0))
            return 1'b0;
        for (int i = 0; i < FRAC_BITS; i++)
        begin
            rem = rem << 1;
            f = f << 1;
            if (rem >= d)
            begin
                rem = rem - d;
                f[0] = 1'b1;
            end
        end
        ip = q[INT_BITS-1:0];
        fp = f;
        return 1'b1;
    endfunction

    function automatic src_pos_t map_coord(input logic [ROW_W-1:0] r,
                                           input logic [COL_W-1:0] c);
        logic signed [SUM_BITS-1:0] rs, cs, nr, nc, den;
        src_pos_t p;
        bit ok;
        rs = $signed({1'b0, r});
        cs = $signed({1'b0, c});
        nr = coefs[CFG_COEF_00] * rs + coefs[CFG_COEF_01] * cs + coefs[CFG_COEF_02];
        nc = coefs[CFG_COEF_10] * rs + coefs[CFG_COEF_11] * cs + coefs[CFG_COEF_12];
        den = coefs[CFG_COEF_20] * rs + coefs[CFG_COEF_21] * cs + $signed(SUM_ONE);
        p = '0;
        ok = 1'b0;
        if (den > 0)
            ok = div_bounded(nr, den, HEIGHT - 2, p.row_i, p.row_f) &&
                 div_bounded(nc, den, WIDTH - 2, p.col_i, p.col_f);
        if (!ok)
            p = '0;
        p.in_bounds = ok;
        return p;
    endfunction

    task automatic write_coef(input cfg_index_t idx, input logic [COEF_BITS-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        coefs[idx] = val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic write_set(input logic [COEF_BITS-1:0] v [NUM_COEFS]);
        for (int i = 0; i < NUM_COEFS; i++)
            write_coef(cfg_index_t'(i), v[i]);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_pos.size() != 0)
            @(posedge clk);
        repeat (PIPE_CYCLES + 4) @(posedge clk);
    endtask

    // one transfer after a gap given by the caller; valid stays up after the
    // transfer so back to back items follow one another without a gap
    task automatic send_coord(input logic [ROW_W-1:0] r, input logic [COL_W-1:0] c,
                              input int gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        out_row <= r;
        out_col <= c;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_pos.push_back(map_coord(r, c));
    endtask

    function automatic int pick_gap(input bit busy);
        if (busy)
            return 0;
        return $urandom_range(0, 3) == 0 ? $urandom_range(0, 16) : 0;
    endfunction

    // random affine-ish or projective set, mostly mapping into the source
    function automatic logic [COEF_BITS-1:0] near_q32(input int lo, input int hi);
        longint v;
        v = longint'($urandom_range(0, hi - lo)) + lo;
        return COEF_BITS'((v <<< 24) + $urandom_range(0, 32'hffffff));
    endfunction

    task automatic random_set();
        logic [COEF_BITS-1:0] v [NUM_COEFS];
        v[0] = near_q32(-30, 90);
        v[1] = near_q32(-30, 30);
        v[2] = near_q32(-3000, 30000);
        v[3] = near_q32(-30, 30);
        v[4] = near_q32(-30, 90);
        v[5] = near_q32(-3000, 30000);
        if ($urandom_range(0, 1))
        begin
            v[6] = COEF_BITS'(longint'($urandom_range(0, 20000)) - 10000);
            v[7] = COEF_BITS'(longint'($urandom_range(0, 20000)) - 10000);
        end
        else
        begin
            v[6] = '0;
            v[7] = '0;
        end
        if ($urandom_range(0, 7) == 0)
            v[$urandom_range(0, 7)] = COEF_BITS'({$urandom, $urandom});
        write_set(v);
    endtask

    // result checker
    always @(posedge clk)
    begin
        src_pos_t got, want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {inside_res, src_row_int, src_col_int, row_frac, col_frac};
            if (pending_pos.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transfer %p", got);
            end
            else
            begin
                want = pending_pos.pop_front();
                checked++;
                if (got.in_bounds)
                    inside_seen++;
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch #%0d: expected %p got %p", checked, want, got);
                end
            end
        end
    end

    // receiver stall
    initial
    begin
        int w;
        out_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            w = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 16) : 0;
            if (drain_hold)
                w = 0;
            if (w != 0)
            begin
                out_stall <= 1'b1;
                repeat (w) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
        end
    end

    initial
    begin
        stim_row_t tbl [$];
        logic [COEF_BITS-1:0] setv [NUM_COEFS];
        int cnt;
        bit burst;

        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        out_row = '0;
        out_col = '0;
        mismatches = 0;
        checked = 0;
        inside_seen = 0;
        stim_done = 1'b0;
        drain_hold = 1'b0;
        coefs[CFG_COEF_00] = COEF_ONE;
        coefs[CFG_COEF_01] = '0;
        coefs[CFG_COEF_02] = '0;
        coefs[CFG_COEF_10] = '0;
        coefs[CFG_COEF_11] = COEF_ONE;
        coefs[CFG_COEF_12] = '0;
        coefs[CFG_COEF_20] = '0;
        coefs[CFG_COEF_21] = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // identity after reset: bounds edges read off directly
        tbl.push_back('{0, 0, 1, '0});
        tbl.push_back('{1, 1, 1, '{1'b1, 10'd1, 10'd1, 16'd0, 16'd0}});
        tbl.push_back('{510, 510, 1, '{1'b1, 10'd510, 10'd510, 16'd0, 16'd0}});
        tbl.push_back('{511, 5, 1, '0});
        tbl.push_back('{5, 511, 1, '0});
        tbl.push_back('{2047, 4095, 1, '0});
        tbl.push_back('{1, 0, 1, '0});
        tbl.push_back('{300, 200, 1, '{1'b1, 10'd300, 10'd200, 16'd0, 16'd0}});
        tbl.push_back('{11'h555, 12'haaa, 0, '0});
        tbl.push_back('{11'h2aa, 12'h555, 0, '0});
        foreach (tbl[i])
        begin
            send_coord(tbl[i].r, tbl[i].c, 0);
            if (tbl[i].fixed && pending_pos[$] !== tbl[i].want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("table row %0d: expected %p got %p", i, tbl[i].want,
                             pending_pos[$]);
            end
        end
        wait_idle();

        // half scale on rows, quarter scale on columns, with offsets: fractions
        setv = '{48'h0000_8000_0000, 48'h0, 48'h0000_8000_0000,
                 48'h0, 48'h0000_4000_0000, 48'h0001_0000_0000,
                 48'h0, 48'h0};
        write_set(setv);
        tbl.delete();
        tbl.push_back('{3, 7, 0, '0});
        tbl.push_back('{1020, 2043, 0, '0});
        tbl.push_back('{1021, 2044, 0, '0});
        tbl.push_back('{0, 0, 0, '0});
        foreach (tbl[i]) send_coord(tbl[i].r, tbl[i].c, $urandom_range(0, 2));
        wait_idle();

        // extremes: most negative and most positive coefficients, zero/negative denominator
        setv = '{48'h8000_0000_0000, 48'h7fff_ffff_ffff, 48'h7fff_ffff_ffff,
                 48'h7fff_ffff_ffff, 48'h8000_0000_0000, 48'h8000_0000_0000,
                 48'hffff_0000_0000, 48'h0};
        write_set(setv);
        send_coord(1, 0, 0);
        send_coord(2047, 4095, 0);
        send_coord(0, 0, 0);
        wait_idle();
        // denominator 2 at row 1: projective divide
        setv = '{48'h0000_0400_0000, 48'h0, 48'h000a_0000_0000,
                 48'h0, 48'h0003_0000_0000, 48'h0000_0000_0001,
                 48'h0001_0000_0000, 48'h0000_0000_0100};
        write_set(setv);
        send_coord(1, 3, 0);
        send_coord(7, 100, 0);
        send_coord(2047, 4095, 0);
        wait_idle();

        cnt = 0;
        while (cnt < 850)
        begin
            random_set();
            burst = $urandom_range(0, 3) == 0;
            for (int k = 0; k < 60 && cnt < 850; k++)
            begin
                if ($urandom_range(0, 4) == 0)
                    send_coord(ROW_W'($urandom), COL_W'($urandom), pick_gap(burst));
                else
                    send_coord(ROW_W'($urandom_range(0, 255)),
                               COL_W'($urandom_range(0, 511)), pick_gap(burst));
                cnt++;
                if (cnt == 400)
                begin
                    // sender waits for a full drain
                    in_valid <= 1'b0;
                    drain_hold = 1'b1;
                    while (pending_pos.size() != 0)
                        @(posedge clk);
                    drain_hold = 1'b0;
                end
            end
            wait_idle();
        end
        stim_done = 1'b1;

        $display("checked %0d transfers, %0d inside the source interior", checked,
                 inside_seen);
        if (mismatches == 0 && pending_pos.size() == 0)
            $display("PASS homography_coordinate_mapper_unit");
        else
            $display("FAIL homography_coordinate_mapper_unit");
        $finish;
    end

endmodule
